// ===== sv/blr_pkg.sv =====
// Package for the bounded record list: sizes, action and status codes,
// and the packed command, result and stored entry types.
// No dependencies; imported by the top level and by the testbench.
`timescale 1ns / 1ps

package blr_pkg;

  // List capacity and width of the assigned ids.
  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;

  // Derived widths: memory address, entry count and id compare width.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (ID_WIDTH > 16) ? ID_WIDTH : 16;

  // Action codes.
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_END   = 3'd1;
  localparam logic [2:0] ACT_REMOVE    = 3'd2;
  localparam logic [2:0] ACT_LOOKUP    = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  // Status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_BADIDX   = 3'd4;
  localparam logic [2:0] STAT_CANCEL   = 3'd5;

  // One command transaction.
  typedef struct packed {
    logic [2:0]  action;
    logic        confirm;
    logic [15:0] grade;
    logic [31:0] record_tag;
    logic [15:0] key_id;
    logic [3:0]  read_index;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [15:0] entry_grade;
    logic [31:0] entry_tag;
    logic [4:0]  entry_count;
  } res_t;

  // One record as it sits in the entry memory.
  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [15:0]         grade;
    logic [31:0]         tag;
  } entry_t;

endpackage

// ===== sv/blr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the record storage of the bounded record list.
`timescale 1ns / 1ps

module blr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; contents have no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bounded_record_list.sv =====
// Top level of the bounded record list: sequencer, ring pointers and result register.
// Depends on blr_pkg and on blr_ram for the record storage.
`timescale 1ns / 1ps

// The list is kept as a ring in one record memory with a head pointer, so
// inserts and removes move a pointer instead of shifting entries. A command
// transaction is taken when start is high and busy is low; its result
// appears on result_o for exactly one cycle with done_o high, in the cycle
// after the last cycle of work, and must be captured then. Inserts, appends
// and every command answered from the count alone leave busy low and may
// follow one another in consecutive cycles. Remove and read index pass
// through the read state for the registered read of the record memory.
// Lookup reads one entry per cycle from the front and stops at the first
// match, or after the last held entry when nothing matches. The memory
// needs no clearing after reset; only held entries are ever read.
module bounded_record_list
  import blr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t result_o
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int IDX_W = (CNT_W > 4) ? CNT_W : 4;

  logic [1:0]          state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ID_WIDTH-1:0] next_id_q, next_id_d;
  logic [PTR_W-1:0]    scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0]    scan_idx_q, scan_idx_d;
  logic [15:0]         key_q, key_d;
  logic [2:0]          pend_stat_q, pend_stat_d;
  logic                done_q, done_d;
  res_t                res_q, res_d;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [PTR_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             accept;
  logic             full;
  logic             empty;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail_ptr;
  logic [SUM_W-1:0] ridx_sum;
  logic [PTR_W-1:0] ridx_ptr;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] scan_inc;
  logic             key_hit;

  // Next ring position with wrap at DEPTH.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Ring position of head plus an offset below DEPTH.
  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    if (s >= SUM_W'(DEPTH)) begin
      r = s - SUM_W'(DEPTH);
    end else begin
      r = s;
    end
    return PTR_W'(r);
  endfunction

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Ring addresses for append, front insert, read index and the scan.
  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail_ptr = ptr_wrap(tail_sum);
  assign ridx_sum = SUM_W'(head_q) + SUM_W'(cmd_i.read_index);
  assign ridx_ptr = ptr_wrap(ridx_sum);
  assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = ptr_inc(head_q);
  assign scan_inc = ptr_inc(scan_addr_q);

  // Lookup compare of the entry that the memory returns this cycle.
  assign key_hit = (CMP_W'(ram_rdata.id) == CMP_W'(key_q));

  // Sequencer: command decode, memory accesses and result formation.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    next_id_d   = next_id_q;
    scan_addr_d = scan_addr_q;
    scan_idx_d  = scan_idx_q;
    key_d       = key_q;
    pend_stat_d = pend_stat_q;
    done_d      = 1'b0;
    res_d       = '0;
    ram_we      = 1'b0;
    ram_waddr   = tail_ptr;
    ram_wdata   = '0;
    ram_raddr   = scan_addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.action) inside
            ACT_INS_FRONT, ACT_INS_END: begin
              done_d = 1'b1;
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                next_id_d      = next_id_q + 1'b1;
                res_d.entry_id = 16'(next_id_d);
                if (!cmd_i.confirm) begin
                  res_d.status = STAT_CANCEL;
                end else begin
                  res_d.status      = STAT_OK;
                  res_d.entry_grade = cmd_i.grade;
                  res_d.entry_tag   = cmd_i.record_tag;
                  ram_we            = 1'b1;
                  ram_wdata.id      = next_id_d;
                  ram_wdata.grade   = cmd_i.grade;
                  ram_wdata.tag     = cmd_i.record_tag;
                  count_d           = count_q + 1'b1;
                  if (cmd_i.action == ACT_INS_FRONT) begin
                    ram_waddr = head_dec;
                    head_d    = head_dec;
                  end else begin
                    ram_waddr = tail_ptr;
                  end
                end
              end
            end
            ACT_REMOVE: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                // Read the front entry; a confirmed remove drops it now.
                ram_raddr = head_q;
                state_d   = S_READ;
                if (cmd_i.confirm) begin
                  pend_stat_d = STAT_OK;
                  head_d      = head_inc;
                  count_d     = count_q - 1'b1;
                end else begin
                  pend_stat_d = STAT_CANCEL;
                end
              end
            end
            ACT_LOOKUP: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                ram_raddr   = head_q;
                scan_addr_d = head_inc;
                scan_idx_d  = '0;
                key_d       = cmd_i.key_id;
                state_d     = S_SCAN;
              end
            end
            ACT_READ: begin
              // Since the count never exceeds DEPTH, an index below the
              // count is always a valid position.
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = STAT_EMPTY;
              end else if (IDX_W'(cmd_i.read_index) >= IDX_W'(count_q)) begin
                done_d       = 1'b1;
                res_d.status = STAT_BADIDX;
              end else begin
                ram_raddr   = ridx_ptr;
                pend_stat_d = STAT_OK;
                state_d     = S_READ;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_d.status = STAT_BADIDX;
            end
          endcase
        end
      end
      S_READ: begin
        done_d            = 1'b1;
        res_d.status      = pend_stat_q;
        res_d.entry_id    = 16'(ram_rdata.id);
        res_d.entry_grade = ram_rdata.grade;
        res_d.entry_tag   = ram_rdata.tag;
        state_d           = S_IDLE;
      end
      S_SCAN: begin
        if (key_hit) begin
          done_d            = 1'b1;
          res_d.status      = STAT_OK;
          res_d.entry_id    = 16'(ram_rdata.id);
          res_d.entry_grade = ram_rdata.grade;
          res_d.entry_tag   = ram_rdata.tag;
          state_d           = S_IDLE;
        end else if (scan_idx_q + 1'b1 == count_q) begin
          done_d       = 1'b1;
          res_d.status = STAT_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          // Fetch the next entry while the current one is compared.
          ram_raddr   = scan_addr_q;
          scan_addr_d = scan_inc;
          scan_idx_d  = scan_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entry_count = 5'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      next_id_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    scan_idx_q  <= scan_idx_d;
    key_q       <= key_d;
    pend_stat_q <= pend_stat_d;
    res_q       <= res_d;
  end

  // Record storage.
  blr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== tb/bounded_record_list_test.sv =====
// Self-checking testbench for the bounded record list: directed and random command
// transactions with an in-order list predictor. Depends on blr_pkg and bounded_record_list.
`timescale 1ns / 1ps

module bounded_record_list_test;
  import blr_pkg::*;

  // Action codes with no defined meaning; the block answers them as bad index.
  localparam logic [2:0] ACT_SPARE_LO = ACT_READ + 3'd1;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 960;
  // Longest lookup plus the result register, with some margin.
  localparam int SETTLE_CYCLES = DEPTH + 8;

  // One slot of the stimulus queue: either a command or one idle cycle.
  typedef struct {
    bit   idle;
    cmd_t cmd;
  } slot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  cmd_t cmd_i  = '0;
  logic done_o;
  res_t result_o;

  slot_t slot_q[$];
  res_t  expected_q[$];
  slot_t drive_slot;
  res_t  seen_expect;

  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;

  // Predicted list contents, in order from the front.
  entry_t              list_mem [DEPTH];
  int                  list_len   = 0;
  logic [ID_WIDTH-1:0] id_counter = '0;

  bounded_record_list dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result that reports one stored record.
  function automatic res_t entry_result(input logic [2:0] status, input entry_t e);
    res_t r;
    r             = '0;
    r.status      = status;
    r.entry_id    = 16'(e.id);
    r.entry_grade = e.grade;
    r.entry_tag   = e.tag;
    return r;
  endfunction

  // Applies one command to the predicted list and returns the result it should give.
  function automatic res_t apply_command(input cmd_t c);
    res_t r;
    int   pos;
    int   hit;
    r        = '0;
    r.status = STAT_BADIDX;
    pos      = 0;
    hit      = -1;
    case (c.action)
      ACT_INS_FRONT, ACT_INS_END: begin
        if (list_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // The id is used up even when the insert is cancelled.
          id_counter = id_counter + 1'b1;
          if (!c.confirm) begin
            r.status   = STAT_CANCEL;
            r.entry_id = 16'(id_counter);
          end else begin
            if (c.action == ACT_INS_FRONT) begin
              for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i - 1];
            end else begin
              pos = list_len;
            end
            list_mem[pos].id    = id_counter;
            list_mem[pos].grade = c.grade;
            list_mem[pos].tag   = c.record_tag;
            list_len++;
            r = entry_result(STAT_OK, list_mem[pos]);
          end
        end
      end
      ACT_REMOVE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (!c.confirm) begin
          r = entry_result(STAT_CANCEL, list_mem[0]);
        end else begin
          r = entry_result(STAT_OK, list_mem[0]);
          for (int i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      ACT_LOOKUP: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // The match nearest the front wins when ids repeat after a wrap.
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_mem[i].id == c.key_id) hit = i;
          end
          if (hit >= 0) r = entry_result(STAT_OK, list_mem[hit]);
          else r.status = STAT_NOTFOUND;
        end
      end
      ACT_READ: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else if (int'(c.read_index) >= list_len) r.status = STAT_BADIDX;
        else r = entry_result(STAT_OK, list_mem[c.read_index]);
      end
      default: r.status = STAT_BADIDX;
    endcase
    r.entry_count = 5'(list_len);
    return r;
  endfunction

  // Command with the given action and confirm and random payload fields.
  function automatic cmd_t random_cmd(input logic [2:0] action, input logic confirm);
    cmd_t c;
    c.action     = action;
    c.confirm    = confirm;
    c.grade      = 16'($urandom);
    c.record_tag = $urandom;
    c.key_id     = 16'($urandom);
    c.read_index = 4'($urandom);
    return c;
  endfunction

  task automatic send(input cmd_t c);
    slot_q.push_back('{idle: 1'b0, cmd: c});
  endtask

  task automatic pause(input int cycles);
    for (int i = 0; i < cycles; i++) slot_q.push_back('{idle: 1'b1, cmd: '0});
  endtask

  // Waits until every queued command has been taken by the block.
  task automatic wait_all_taken();
    while (slot_q.size() != 0 || accepted_count != issued_count) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Driver: presents the next command once the current one is taken; idle slots
  // keep start low and put random values on the command bus.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || accepted_count == issued_count)) begin
      if (slot_q.size() != 0 && !slot_q[0].idle) begin
        drive_slot = slot_q.pop_front();
        cmd_i <= drive_slot.cmd;
        start <= 1'b1;
        issued_count++;
      end else begin
        if (slot_q.size() != 0) void'(slot_q.pop_front());
        cmd_i <= random_cmd(3'($urandom), 1'($urandom));
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result strobe against the oldest prediction, then
  // predicts the command transaction accepted at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got %0h", $time, result_o);
        end else begin
          seen_expect = expected_q.pop_front();
          check_field("status", 32'(seen_expect.status), 32'(result_o.status));
          check_field("entry_id", 32'(seen_expect.entry_id), 32'(result_o.entry_id));
          check_field("entry_grade", 32'(seen_expect.entry_grade),
                      32'(result_o.entry_grade));
          check_field("entry_tag", seen_expect.entry_tag, result_o.entry_tag);
          check_field("entry_count", 32'(seen_expect.entry_count),
                      32'(result_o.entry_count));
        end
      end
      if (start && !busy) begin
        expected_q.push_back(apply_command(cmd_i));
        accepted_count++;
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    cmd_t                c;
    int                  counted;
    int                  seg_kind;
    int                  seg_len;
    bit                  seg_idles;
    logic [15:0]         id_guess;
    logic [ID_WIDTH-1:0] wrap_base;

    counted  = 0;
    id_guess = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: remove, lookup and read on an empty list.
    send(random_cmd(ACT_REMOVE, 1'b1));
    send(random_cmd(ACT_LOOKUP, 1'b1));
    c = random_cmd(ACT_READ, 1'b0);
    c.read_index = '0;
    send(c);
    // A cancelled insert uses up id 1; then ids 2, 3 and 4 build the list 4, 2, 3.
    send(random_cmd(ACT_INS_FRONT, 1'b0));
    c = random_cmd(ACT_INS_FRONT, 1'b1);
    c.grade      = '0;
    c.record_tag = '0;
    send(c);
    c = random_cmd(ACT_INS_END, 1'b1);
    c.grade      = '1;
    c.record_tag = '1;
    send(c);
    send(random_cmd(ACT_INS_FRONT, 1'b1));
    // Lookups: hit at the back, hit at the front, and two misses.
    c = random_cmd(ACT_LOOKUP, 1'b1);
    c.key_id = 16'd3;
    send(c);
    c.key_id = 16'd4;
    send(c);
    c.key_id = '1;
    send(c);
    c.key_id = '0;
    c.confirm = 1'b0;
    send(c);
    // Reads: first, last, just past the end, and the top index.
    c = random_cmd(ACT_READ, 1'b1);
    c.read_index = 4'd0;
    send(c);
    c.read_index = 4'd2;
    send(c);
    c.read_index = 4'd3;
    send(c);
    c.read_index = '1;
    send(c);
    // Cancelled and confirmed removes, a cancelled append, and the spare codes.
    send(random_cmd(ACT_REMOVE, 1'b0));
    send(random_cmd(ACT_REMOVE, 1'b1));
    send(random_cmd(ACT_INS_END, 1'b0));
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) send(random_cmd(3'(a), 1'b1));
    id_guess = 16'd5;

    // Random: segments that fill the list, drain it, or mix all actions.
    while (counted < RANDOM_ITEMS) begin
      seg_kind  = $urandom_range(0, 9);
      seg_len   = $urandom_range(3, 20);
      seg_idles = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < seg_len; k++) begin
        if (seg_idles && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
        if (seg_kind < 4) begin
          c = random_cmd(3'($urandom_range(ACT_INS_FRONT, ACT_INS_END)),
                         $urandom_range(0, 9) != 0);
        end else if (seg_kind < 6) begin
          c = random_cmd(ACT_REMOVE, $urandom_range(0, 9) != 0);
        end else begin
          c = random_cmd(3'($urandom_range(ACT_INS_FRONT, ACT_READ)),
                         $urandom_range(0, 5) != 0);
          // Aim most lookups at recently issued ids.
          if (c.action == ACT_LOOKUP && $urandom_range(0, 4) != 0)
            c.key_id = id_guess - 16'($urandom_range(0, 24));
        end
        if (c.action == ACT_INS_FRONT || c.action == ACT_INS_END) id_guess++;
        if ($urandom_range(0, 39) == 0) begin
          c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else begin
          counted++;
        end
        send(c);
      end
    end

    // Back to back: empty the list, add three records, then insert at both
    // ends and look up the most recent ids.
    for (int k = 0; k < DEPTH; k++) send(random_cmd(ACT_REMOVE, 1'b1));
    for (int k = 0; k < 3; k++) send(random_cmd(ACT_INS_END, 1'b1));
    wait_all_taken();
    wrap_base = id_counter - 2'd2;
    send(random_cmd(ACT_INS_FRONT, 1'b1));
    send(random_cmd(ACT_INS_END, 1'b1));
    // The three appended records and the one inserted at the front.
    for (int k = 0; k < 4; k++) begin
      c = random_cmd(ACT_LOOKUP, 1'b1);
      c.key_id = 16'(wrap_base + ID_WIDTH'(k));
      send(c);
    end
    for (int k = 0; k < 6; k++) begin
      c = random_cmd(ACT_READ, 1'b1);
      c.read_index = 4'(k);
      send(c);
    end
    // Fill past capacity, then look up and remove at the full list.
    for (int k = 0; k < DEPTH - 4; k++)
      send(random_cmd(3'($urandom_range(ACT_INS_FRONT, ACT_INS_END)), 1'b1));
    c = random_cmd(ACT_LOOKUP, 1'b1);
    c.key_id = 16'(wrap_base + 1'b1);
    send(c);
    send(random_cmd(ACT_REMOVE, 1'b1));
    c.key_id = 16'(wrap_base);
    send(c);

    // Let the last results arrive, then watch for stray strobes.
    wait_all_taken();
    for (int k = 0; k < 200 && expected_q.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results missing, expected %0h, got none", $time,
               expected_q.size(), expected_q[0]);
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/blr_pkg.sv
sv/blr_ram.sv
sv/bounded_record_list.sv
tb/bounded_record_list_test.sv
